// ----- design/epif_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package epif_pkg;
    localparam int MaxCandidates = 64;
    localparam int KeyBits = 64;
    localparam int FieldBits = 64;
    localparam int WsBits = 7;
    localparam int WcBits = 16;
    localparam int CfgIdxBits = 1;
    localparam logic [CfgIdxBits-1:0] RegWindowSize = 1'd0;
    localparam logic [CfgIdxBits-1:0] RegWindowCount = 1'd1;
    localparam int QDepth = 4;

    // one transaction handed from the front to the back
    typedef struct packed {
        logic [FieldBits-1:0] key;
        logic                 load;
        logic                 clear;
        logic [WsBits-1:0]    pos;
        logic                 age;
        logic                 report;
    } t_work;
endpackage
`default_nettype wire

// ----- design/epif_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module epif_front #(
    parameter int MAX_CANDIDATES = epif_pkg::MaxCandidates
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_take,
    input  wire logic [epif_pkg::FieldBits-1:0] i_key,
    input  wire logic [epif_pkg::WsBits-1:0]  i_ws,
    input  wire logic [epif_pkg::WcBits-1:0]  i_wc,
    output epif_pkg::t_work                   o_work
);
    logic [epif_pkg::WsBits-1:0] r_pos, n_pos, ws_eff, pos_inc;
    logic [epif_pkg::WcBits-1:0] r_win, n_win, wc_eff, win_inc;
    logic wend;

    always_comb begin
        ws_eff = (i_ws == '0) ? epif_pkg::WsBits'(1) : i_ws;
        if (ws_eff > epif_pkg::WsBits'(MAX_CANDIDATES))
            ws_eff = epif_pkg::WsBits'(MAX_CANDIDATES);
        wc_eff = (i_wc == '0) ? epif_pkg::WcBits'(1) : i_wc;
        pos_inc = r_pos + 1'b1;
        win_inc = r_win + 1'b1;
        wend = (pos_inc >= ws_eff) || (pos_inc == '0);
        n_pos = wend ? '0 : pos_inc;
        n_win = r_win;
        o_work.report = 1'b0;
        if (wend) begin
            n_win = win_inc;
            if (win_inc >= wc_eff || win_inc == '0) begin
                n_win = '0;
                o_work.report = 1'b1;
            end
        end
        o_work.key = i_key;
        o_work.load = (r_win == '0);
        o_work.clear = (r_win == '0) && (r_pos == '0);
        o_work.pos = r_pos;
        o_work.age = wend && (r_win != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_win <= '0;
        end else if (i_take) begin
            r_pos <= n_pos;
            r_win <= n_win;
        end
    end
endmodule
`default_nettype wire

// ----- design/epif_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module epif_queue (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  epif_pkg::t_work i_data,
    input  wire logic       i_pop,
    output epif_pkg::t_work o_data,
    output logic            o_empty,
    output logic            o_full
);
    localparam int AW = $clog2(epif_pkg::QDepth);
    epif_pkg::t_work r_mem [epif_pkg::QDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full = (r_cnt == (AW+1)'(epif_pkg::QDepth));
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule
`default_nettype wire

// ----- design/epif_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module epif_back #(
    parameter int MAX_CANDIDATES = epif_pkg::MaxCandidates,
    parameter int KEY_BITS = epif_pkg::KeyBits
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_empty,
    input  epif_pkg::t_work                     i_work,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [epif_pkg::FieldBits-1:0]      o_key,
    output logic                                o_found,
    output logic                                o_last
);
    localparam int IW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CW = $clog2(MAX_CANDIDATES + 1);

    typedef enum logic [1:0] {
        S_RUN = 2'b01,
        S_REP = 2'b10
    } t_state;

    logic [KEY_BITS-1:0] r_keys [MAX_CANDIDATES];
    logic [MAX_CANDIDATES-1:0] r_alive, r_seen, r_live;
    logic [MAX_CANDIDATES-1:0] hit;
    t_state r_state;
    logic [CW-1:0] r_idx;
    logic [KEY_BITS-1:0] r_pend_key;
    logic r_pend;
    logic [KEY_BITS-1:0] wkey, ckey;
    logic cur_ok, dup, out_free;
    logic [IW-1:0] cidx;

    assign wkey = i_work.key[KEY_BITS-1:0];
    assign out_free = !o_valid || !i_stall;
    assign o_pop = (r_state == S_RUN) && !i_empty;
    assign cidx = r_idx[IW-1:0];
    assign ckey = r_keys[cidx];
    assign cur_ok = (r_idx < CW'(MAX_CANDIDATES)) && r_live[cidx];

    // one parallel compare per item, against all alive unseen candidates
    always_comb begin
        for (int j = 0; j < MAX_CANDIDATES; j++) begin
            hit[j] = r_alive[j] && !r_seen[j] && (r_keys[j] == wkey);
        end
    end

    // duplicate: an earlier live entry with the same key
    always_comb begin
        dup = 1'b0;
        for (int j = 0; j < MAX_CANDIDATES; j++) begin
            if (IW'(j) < cidx && r_live[j] && r_keys[j] == ckey) dup = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_work.load && i_work.pos < epif_pkg::WsBits'(MAX_CANDIDATES))
            r_keys[i_work.pos[IW-1:0]] <= wkey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '0;
            r_seen <= '0;
            r_live <= '0;
            r_state <= S_RUN;
            r_idx <= '0;
            r_pend <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            logic v;
            // held while stalled, dropped once taken
            v = o_valid && i_stall;
            case (r_state)
                S_RUN: begin
                    if (o_pop) begin
                        logic [MAX_CANDIDATES-1:0] a, s;
                        a = r_alive;
                        s = r_seen;
                        if (i_work.load) begin
                            if (i_work.clear) begin
                                a = '0;
                                s = '0;
                            end
                            if (i_work.pos < epif_pkg::WsBits'(MAX_CANDIDATES)) begin
                                a[i_work.pos[IW-1:0]] = 1'b1;
                                s[i_work.pos[IW-1:0]] = 1'b0;
                            end
                        end else begin
                            s = s | hit;
                        end
                        if (i_work.age) begin
                            a = a & s;
                            s = '0;
                        end
                        r_alive <= a;
                        r_seen <= s;
                        if (i_work.report) begin
                            r_live <= a;
                            r_state <= S_REP;
                            r_idx <= '0;
                            r_pend <= 1'b0;
                        end
                    end
                end
                S_REP: begin
                    // walk entries; hold one found key back to know the last
                    if (r_idx < CW'(MAX_CANDIDATES)) begin
                        if (cur_ok && !dup) begin
                            if (!r_pend) begin
                                r_pend <= 1'b1;
                                r_pend_key <= ckey;
                                r_idx <= r_idx + 1'b1;
                            end else if (out_free) begin
                                v = 1'b1;
                                o_key <= epif_pkg::FieldBits'(r_pend_key);
                                o_found <= 1'b1;
                                o_last <= 1'b0;
                                r_pend_key <= ckey;
                                r_idx <= r_idx + 1'b1;
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else if (out_free) begin
                        v = 1'b1;
                        o_last <= 1'b1;
                        o_found <= r_pend;
                        o_key <= r_pend ? epif_pkg::FieldBits'(r_pend_key) : '0;
                        r_state <= S_RUN;
                    end
                end
                default: r_state <= S_RUN;
            endcase
            o_valid <= v;
        end
    end
endmodule
`default_nettype wire

// ----- design/exact_persistent_item_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Persistent item filter: keys stream in one per cycle while o_stall is low, in
// windows of window_size; the first window loads the candidate table, later windows
// each must hit every surviving candidate. Input and matching run at one transaction
// per cycle, unless the queue is full, through a four-deep queue into a parallel
// compare over all candidates. At the end of window_count windows the back end
// scans the table, one entry per cycle unless the output stalls, emitting each
// distinct survivor in first-appearance order, is_last on the final one, or one
// not-found result; the scan lets in at most four transactions, till the queue fills.
module exact_persistent_item_filter #(
    parameter int MAX_CANDIDATES = epif_pkg::MaxCandidates,
    parameter int KEY_BITS = epif_pkg::KeyBits
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_item_key,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_persistent_key,
    output logic             o_found,
    output logic             o_is_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [epif_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    logic [epif_pkg::WsBits-1:0] r_ws;
    logic [epif_pkg::WcBits-1:0] r_wc;
    epif_pkg::t_work fw, bw;
    logic take, pop, empty, full;
    logic [63:0] mkey;

    assign o_cfg_ready = 1'b1;
    assign o_stall = full;
    assign take = i_valid && !full;
    assign mkey = {{(64-KEY_BITS){1'b0}}, i_item_key[KEY_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= epif_pkg::WsBits'(64);
            r_wc <= epif_pkg::WcBits'(2);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                epif_pkg::RegWindowSize: r_ws <= i_cfg_data[epif_pkg::WsBits-1:0];
                epif_pkg::RegWindowCount: r_wc <= i_cfg_data[epif_pkg::WcBits-1:0];
                default: ;
            endcase
        end
    end

    epif_front #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_key(mkey),
        .i_ws(r_ws), .i_wc(r_wc), .o_work(fw)
    );

    epif_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(take), .i_data(fw),
        .i_pop(pop), .o_data(bw), .o_empty(empty), .o_full(full)
    );

    epif_back #(.MAX_CANDIDATES(MAX_CANDIDATES), .KEY_BITS(KEY_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_work(bw), .o_pop(pop),
        .o_valid(o_valid), .i_stall(i_stall), .o_key(o_persistent_key),
        .o_found(o_found), .o_last(o_is_last)
    );
endmodule
`default_nettype wire
